FILE: hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

  // field widths at the ports
  localparam int BASE_BITS      = 63;
  localparam int EXP_FIELD_BITS = 63;
  localparam int MOD_FIELD_BITS = 31;
  localparam int POWER_BITS     = 31;

  // exponent bits scanned and modulus bits kept
  localparam int EXP_BITS = 63;
  localparam int MOD_BITS = 31;

  // bit counter of the serial multiplier, sized for the longest operand
  localparam int CNT_W    = $clog2(BASE_BITS + 1);
  localparam int PAD_BITS = BASE_BITS - MOD_BITS;

  localparam longint MODULUS_RESET = 64'd1000000007;

endpackage

FILE: hw/rtl/modular_exponentiation_top.sv
`timescale 1ns / 1ps

// modular exponentiation: power = base ** exponent mod modulus
// command channel: base and exponent are taken at a clock edge with start
// high and busy low; busy stays high until the result is out.
// result channel: power is valid for exactly one cycle while done is high;
// the receiver cannot stall it, so it must take the result in that cycle.
// configuration: modulus is written at any edge with modulus_we high; the
// user must write it only while busy is low; the block does not enforce it.
// reset loads 1000000007. the base is first reduced by m with one modular
// multiply, then each scanned exponent bit costs one square plus one
// multiply when the bit is set; scanning ends at the highest set bit, whose
// square is skipped. a zero exponent or zero modulus answers in the cycle
// after start, without the multiplier. the shared bit-serial multiplier
// sets the pace, one item at a time.
// reset clears the controller and abandons any item in progress.
module modular_exponentiation_top import mexp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [BASE_BITS-1:0]      base,
  input  logic [EXP_FIELD_BITS-1:0] exponent,
  input  logic                      modulus_we,
  input  logic [MOD_FIELD_BITS-1:0] modulus,
  output logic                      done,
  output logic [POWER_BITS-1:0]     power
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_STEP   = 5'b00100,
    S_ACC    = 5'b01000,
    S_SQ     = 5'b10000
  } state_t;

  state_t state;

  logic [MOD_BITS-1:0]  m;
  logic [MOD_BITS-1:0]  acc;
  logic [MOD_BITS-1:0]  b;
  logic [EXP_BITS-1:0]  e;

  logic                 mul_go;
  logic [BASE_BITS-1:0] mul_x;
  logic [CNT_W-1:0]     mul_len;
  logic [MOD_BITS-1:0]  mul_y;
  logic                 mul_done;
  logic [MOD_BITS-1:0]  mul_prod;

  mexp_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .x    (mul_x),
    .len  (mul_len),
    .y    (mul_y),
    .m    (m),
    .done (mul_done),
    .prod (mul_prod)
  );

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      m <= MOD_BITS'(MODULUS_RESET);
    end else if (modulus_we) begin
      m <= modulus[MOD_BITS-1:0];
    end
  end

  // controller and operand registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mul_go <= 1'b0;
      done   <= 1'b0;
    end else begin
      mul_go <= 1'b0;
      done   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            e <= exponent[EXP_BITS-1:0];
            if (exponent[EXP_BITS-1:0] == '0) begin
              power <= POWER_BITS'(1);
              done  <= 1'b1;
            end else if (m == '0) begin
              power <= '0;
              done  <= 1'b1;
            end else begin
              // reduce the base first
              mul_x   <= base;
              mul_len <= CNT_W'(BASE_BITS);
              mul_y   <= MOD_BITS'(1);
              mul_go  <= 1'b1;
              acc     <= (m == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
              state   <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mul_done) begin
            b     <= mul_prod;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          // multiply into the result on a set bit, else go straight to squaring
          mul_len <= CNT_W'(MOD_BITS);
          mul_y   <= b;
          mul_go  <= 1'b1;
          if (e[0]) begin
            mul_x <= {acc, {PAD_BITS{1'b0}}};
            state <= S_ACC;
          end else begin
            mul_x <= {b, {PAD_BITS{1'b0}}};
            state <= S_SQ;
          end
        end
        S_ACC: begin
          if (mul_done) begin
            acc <= mul_prod;
            if ((e >> 1) == '0) begin
              // no set bits left: the result is final
              power <= POWER_BITS'(mul_prod);
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              mul_x   <= {b, {PAD_BITS{1'b0}}};
              mul_len <= CNT_W'(MOD_BITS);
              mul_y   <= b;
              mul_go  <= 1'b1;
              state   <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (mul_done) begin
            b     <= mul_prod;
            e     <= e >> 1;
            state <= S_STEP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: hw/rtl/mexp_mul.sv
`timescale 1ns / 1ps

// bit-serial modular multiply: prod = (x * y) mod m, x scanned msb first
// x is left-aligned in a BASE_BITS register, len gives the number of bits
// with y = 1 the same loop reduces x by m
module mexp_mul import mexp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [BASE_BITS-1:0] x,
  input  logic [CNT_W-1:0]    len,
  input  logic [MOD_BITS-1:0] y,
  input  logic [MOD_BITS-1:0] m,
  output logic                done,
  output logic [MOD_BITS-1:0] prod
);

  logic                 run;
  logic [BASE_BITS-1:0] xs;
  logic [CNT_W-1:0]     cnt;
  logic [MOD_BITS-1:0]  yr;
  logic [MOD_BITS-1:0]  r;
  logic [MOD_BITS-1:0]  r_next;

  logic [MOD_BITS:0] mw;
  logic [MOD_BITS:0] dbl;
  logic [MOD_BITS:0] dbl_red;
  logic [MOD_BITS:0] sum;
  logic [MOD_BITS:0] sum_red;

  // one step: r = (2r mod m + bit * y) mod m, each part a single compare-subtract
  always_comb begin
    mw      = {1'b0, m};
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= mw) ? (dbl - mw) : dbl;
    sum     = {1'b0, dbl_red[MOD_BITS-1:0]} + (xs[BASE_BITS-1] ? {1'b0, yr} : '0);
    sum_red = (sum >= mw) ? (sum - mw) : sum;
    r_next  = sum_red[MOD_BITS-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
      end else if (run && cnt == CNT_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (go) begin
      xs  <= x;
      cnt <= len;
      yr  <= y;
      r   <= '0;
    end else if (run) begin
      xs  <= {xs[BASE_BITS-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
      r   <= r_next;
    end
  end

  assign prod = r;

endmodule
